/* hw/rtl/abvw_pkg.sv */
// Shared types, codes and constants of the arcade board I/O and video write block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package abvw_pkg;

	// Bus action codes.
	typedef enum logic [1:0] {
		ACT_MEM_WRITE   = 2'd0,
		ACT_PORT_READ   = 2'd1,
		ACT_PORT_WRITE  = 2'd2,
		ACT_TABLE_WRITE = 2'd3
	} action_t;

	// Port numbers on the I/O bus.
	localparam logic [15:0] PORT_IN_ZERO      = 16'd0;
	localparam logic [15:0] PORT_IN_ONE       = 16'd1;
	localparam logic [15:0] PORT_IN_TWO       = 16'd2;
	localparam logic [15:0] PORT_SHIFT_WINDOW = 16'd3;
	localparam logic [15:0] PORT_SHIFT_AMOUNT = 16'd2;
	localparam logic [15:0] PORT_SOUND_A      = 16'd3;
	localparam logic [15:0] PORT_SHIFT_DATA   = 16'd4;
	localparam logic [15:0] PORT_SOUND_B      = 16'd5;

	// Video RAM window and color table layout.
	localparam logic [15:0] VIDEO_FIRST = 16'h2400;
	localparam logic [15:0] VIDEO_END   = 16'h4000;
	localparam logic [9:0]  COLOR_BASE  = 10'h080;
	localparam int          COLOR_TABLE_DEPTH_DEF = 1024;
	localparam int          OVERLAY_ENTRIES = 1024;

	// One video byte becomes this many pixel results.
	localparam int          BEATS     = 8;
	localparam logic [2:0]  LAST_BEAT = 3'(BEATS - 1);

	// Overlay colors.
	localparam logic [2:0] COLOR_WHITE = 3'd7;
	localparam logic [2:0] COLOR_RED   = 3'd4;
	localparam logic [2:0] COLOR_GREEN = 3'd1;
	localparam logic [2:0] COLOR_NONE  = 3'd0;

	// One accepted bus request as held in the input register.
	typedef struct packed {
		action_t     action;
		logic [15:0] address;
		logic [7:0]  data;
		logic [7:0]  port_zero;
		logic [7:0]  port_one;
		logic [7:0]  port_two;
	} item_t;

	// Everything the output stage needs to play out the results of one request.
	typedef struct packed {
		logic       pixel;
		logic [7:0] row_base;
		logic [7:0] column;
		logic [2:0] color;
		logic [7:0] bits;
		logic [7:0] read_value;
		logic [7:0] sound_a;
		logic [7:0] sound_b;
	} result_t;

	// Power-up overlay color of one table entry.
	function automatic logic [2:0] overlay_color(input logic [31:0] idx);
		logic [4:0] j;
		logic [2:0] c;
		j = idx[4:0];
		if (idx >= 32'(OVERLAY_ENTRIES)) begin
			c = COLOR_NONE;
		end else if (j >= 5'd2 && j <= 5'd8) begin
			c = COLOR_RED;
		end else if (j >= 5'd24 && j <= 5'd27) begin
			c = COLOR_GREEN;
		end else begin
			c = COLOR_WHITE;
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/abvw_color_mem.sv */
// Color table memory with a power-up fill sweep that loads the overlay pattern.
// Depends on abvw_pkg for the overlay function.
`default_nettype none

module abvw_color_mem #(
	parameter int DEPTH = abvw_pkg::COLOR_TABLE_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [2:0]    wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [2:0]    rd_data,
	output logic               busy
);
	import abvw_pkg::*;

	logic [2:0]  mem [DEPTH];
	logic [AW:0] sweep_q;

	assign busy = (sweep_q < (AW+1)'(DEPTH));

	// The fill sweep walks every entry once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
		end else if (busy) begin
			sweep_q <= sweep_q + 1'b1;
		end
	end

	// Single write port, shared by the sweep and by table write requests.
	always_ff @(posedge clk) begin
		if (busy) begin
			mem[sweep_q[AW-1:0]] <= overlay_color(32'(sweep_q));
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/abvw_exec.sv */
// Executes one request: shifter and sound latch state, port reads, pixel setup.
// Depends on abvw_pkg for the item and result structs and the port codes.
`default_nettype none

module abvw_exec (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire abvw_pkg::item_t  item,
	input  wire logic [2:0]       color,
	input  wire logic             advance,
	output abvw_pkg::result_t     res
);
	import abvw_pkg::*;

	logic [7:0]  shift_high_q, shift_low_q;
	logic [2:0]  shift_amount_q;
	logic [7:0]  sound_a_q, sound_b_q;

	logic [7:0]  shift_high_nxt, shift_low_nxt;
	logic [2:0]  shift_amount_nxt;
	logic [7:0]  sound_a_nxt, sound_b_nxt;

	logic        is_video;
	logic [15:0] offset;
	logic [4:0]  y;
	logic [7:0]  x;
	logic [15:0] window;
	logic [7:0]  read_value;

	// Video address decode and the rotated pixel position.
	assign is_video = (item.action == ACT_MEM_WRITE) && (item.address >= VIDEO_FIRST)
		&& (item.address < VIDEO_END);
	assign offset   = item.address - VIDEO_FIRST;
	assign y        = offset[4:0];
	assign x        = offset[12:5];
	assign window   = 16'({shift_high_q, shift_low_q} << shift_amount_q);

	// Port read mux.
	always_comb begin
		read_value = '0;
		if (item.action == ACT_PORT_READ) begin
			case (item.address)
				PORT_IN_ZERO:      read_value = item.port_zero;
				PORT_IN_ONE:       read_value = item.port_one;
				PORT_IN_TWO:       read_value = item.port_two;
				PORT_SHIFT_WINDOW: read_value = window[15:8];
				default:           read_value = '0;
			endcase
		end
	end

	// Port writes; the watchdog and unknown ports change nothing.
	always_comb begin
		shift_high_nxt   = shift_high_q;
		shift_low_nxt    = shift_low_q;
		shift_amount_nxt = shift_amount_q;
		sound_a_nxt      = sound_a_q;
		sound_b_nxt      = sound_b_q;
		if (item.action == ACT_PORT_WRITE) begin
			case (item.address)
				PORT_SHIFT_AMOUNT: shift_amount_nxt = item.data[2:0];
				PORT_SOUND_A:      sound_a_nxt = item.data;
				PORT_SHIFT_DATA: begin
					shift_low_nxt  = shift_high_q;
					shift_high_nxt = item.data;
				end
				PORT_SOUND_B:      sound_b_nxt = item.data;
				default:           ;
			endcase
		end
	end

	// Result record handed to the output stage.
	always_comb begin
		res.pixel      = is_video;
		res.row_base   = is_video ? (8'd255 - {y, 3'b000}) : '0;
		res.column     = is_video ? x : '0;
		res.color      = is_video ? color : COLOR_NONE;
		res.bits       = is_video ? item.data : '0;
		res.read_value = read_value;
		res.sound_a    = sound_a_nxt;
		res.sound_b    = sound_b_nxt;
	end

	// State moves on when the request leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_high_q   <= '0;
			shift_low_q    <= '0;
			shift_amount_q <= '0;
			sound_a_q      <= '0;
			sound_b_q      <= '0;
		end else if (advance) begin
			shift_high_q   <= shift_high_nxt;
			shift_low_q    <= shift_low_nxt;
			shift_amount_q <= shift_amount_nxt;
			sound_a_q      <= sound_a_nxt;
			sound_b_q      <= sound_b_nxt;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/abvw_out.sv */
// Output stage: result register and beat counter that plays out eight pixels per video byte.
// Depends on abvw_pkg for the result struct and beat constants.
`default_nettype none

module abvw_out (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire abvw_pkg::result_t res,
	output logic                   can_load,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   pixel_write,
	output logic [7:0]             pixel_row,
	output logic [7:0]             pixel_column,
	output logic [2:0]             pixel_color,
	output logic [7:0]             read_value,
	output logic [7:0]             sound_latch_a,
	output logic [7:0]             sound_latch_b,
	output logic                   last
);
	import abvw_pkg::*;

	logic       valid_q;
	logic [2:0] beat_q;
	result_t    res_q;
	logic       final_beat;

	assign final_beat = !res_q.pixel || (beat_q == LAST_BEAT);
	assign can_load   = !valid_q || (out_ready && final_beat);

	// Control: valid flag and beat counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= '0;
		end else if (can_load) begin
			valid_q <= load;
			beat_q  <= '0;
		end else if (out_ready) begin
			beat_q  <= beat_q + 1'b1;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			res_q <= res;
		end
	end

	// Per-beat fields: the row walks down one pixel per bit, bit 0 first.
	assign out_valid     = valid_q;
	assign pixel_write   = res_q.pixel;
	assign pixel_row     = res_q.pixel ? (res_q.row_base - 8'(beat_q)) : '0;
	assign pixel_column  = res_q.column;
	assign pixel_color   = (res_q.pixel && res_q.bits[beat_q]) ? res_q.color : COLOR_NONE;
	assign read_value    = res_q.read_value;
	assign sound_latch_a = res_q.sound_a;
	assign sound_latch_b = res_q.sound_b;
	assign last          = final_beat;

endmodule

`default_nettype wire

/* hw/rtl/arcade_board_io_and_video_write_top.sv */
// Top level of the arcade board I/O and video write block.
// Depends on abvw_pkg, abvw_color_mem, abvw_exec and abvw_out.
`default_nettype none

// Each request is one bus action. Port reads, port writes, table writes and memory writes
// outside video RAM give one result; a write into video RAM at 0x2400..0x3FFF gives eight
// pixel results, bit 0 first, one per cycle from the output beat counter while out_ready
// is high. A request passes an input register (the color table read is issued at the
// accepting edge) and then the output register, which offers its first result.
// Single-result requests can follow each other every cycle while out_ready stays high,
// but a video write holds the output until all eight of its results are taken.
// After reset the color table is filled with the overlay pattern, one entry per cycle,
// until every entry is written; in_ready stays low during that pass.
module arcade_board_io_and_video_write_top #(
	parameter int COLOR_TABLE_DEPTH = abvw_pkg::COLOR_TABLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [15:0] address,
	input  wire logic [7:0]  data,
	input  wire logic [7:0]  input_port_zero,
	input  wire logic [7:0]  input_port_one,
	input  wire logic [7:0]  input_port_two,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             pixel_write,
	output logic [7:0]       pixel_row,
	output logic [7:0]       pixel_column,
	output logic [2:0]       pixel_color,
	output logic [7:0]       read_value,
	output logic [7:0]       sound_latch_a,
	output logic [7:0]       sound_latch_b,
	output logic             last
);
	import abvw_pkg::*;

	localparam int AW = $clog2(COLOR_TABLE_DEPTH);

	item_t       item_in;
	item_t       item_s1;
	logic        valid_s1;
	logic        in_accept;
	logic        advance;
	logic        can_load;
	logic        busy;
	logic        in_video;
	logic [15:0] in_offset;
	logic [9:0]  color_idx;
	logic        table_wr;
	logic [2:0]  color;
	result_t     res;

	// Request as presented on the input ports.
	always_comb begin
		item_in.action    = action_t'(action);
		item_in.address   = address;
		item_in.data      = data;
		item_in.port_zero = input_port_zero;
		item_in.port_one  = input_port_one;
		item_in.port_two  = input_port_two;
	end

	// Handshake of the input register.
	assign advance   = valid_s1 && can_load;
	assign in_ready  = !busy && (!valid_s1 || can_load);
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= item_in;
		end
	end

	// Color table access happens at acceptance so table writes and reads keep request order.
	assign in_video  = (item_in.action == ACT_MEM_WRITE) && (address >= VIDEO_FIRST)
		&& (address < VIDEO_END);
	assign in_offset = address - VIDEO_FIRST;
	assign color_idx = {in_offset[12:8], in_offset[4:0]} + COLOR_BASE;
	assign table_wr  = in_accept && (item_in.action == ACT_TABLE_WRITE)
		&& (address < 16'(COLOR_TABLE_DEPTH));

	abvw_color_mem #(
		.DEPTH (COLOR_TABLE_DEPTH),
		.AW    (AW)
	) u_color_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (table_wr),
		.wr_addr (address[AW-1:0]),
		.wr_data (data[2:0]),
		.rd_en   (in_accept && in_video),
		.rd_addr (AW'(color_idx)),
		.rd_data (color),
		.busy    (busy)
	);

	abvw_exec u_exec (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_s1),
		.color   (color),
		.advance (advance),
		.res     (res)
	);

	abvw_out u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (valid_s1),
		.res           (res),
		.can_load      (can_load),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_write   (pixel_write),
		.pixel_row     (pixel_row),
		.pixel_column  (pixel_column),
		.pixel_color   (pixel_color),
		.read_value    (read_value),
		.sound_latch_a (sound_latch_a),
		.sound_latch_b (sound_latch_b),
		.last          (last)
	);

endmodule

`default_nettype wire

/* dv/arcade_board_io_and_video_write_top_tb.sv */
// Self-checking testbench for arcade_board_io_and_video_write_top.
// It drives bus requests and checks every result against its own model or a typed-in value.
// Depends on abvw_pkg and the RTL under hw/rtl; nothing else.
`timescale 1ns / 100ps

module arcade_board_io_and_video_write_top_tb;

	import abvw_pkg::*;

	localparam int TABLE_DEPTH  = COLOR_TABLE_DEPTH_DEF;
	localparam int N_DIRECTED   = 26;
	localparam int N_RANDOM     = 334;
	localparam int PAUSE_AT     = 250;
	localparam int LONG_HOLD_AT = 150;
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int MAX_PRINTED  = 30;

	// One bus request, with an optional typed-in single result.
	typedef struct packed {
		action_t     act;
		logic [15:0] addr;
		logic [7:0]  dat;
		logic [7:0]  p0;
		logic [7:0]  p1;
		logic [7:0]  p2;
		logic        typed;
		logic [7:0]  t_rv;
		logic [7:0]  t_sa;
		logic [7:0]  t_sb;
	} bus_req_t;

	// One result as seen on the output channel.
	typedef struct packed {
		logic       pw;
		logic [7:0] row;
		logic [7:0] col;
		logic [2:0] color;
		logic [7:0] rv;
		logic [7:0] sa;
		logic [7:0] sb;
		logic       lst;
	} bus_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	action_t     action = ACT_MEM_WRITE;
	logic [15:0] address = 16'd0;
	logic [7:0]  data = 8'd0;
	logic [7:0]  input_port_zero = 8'd0;
	logic [7:0]  input_port_one = 8'd0;
	logic [7:0]  input_port_two = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        pixel_write;
	logic [7:0]  pixel_row;
	logic [7:0]  pixel_column;
	logic [2:0]  pixel_color;
	logic [7:0]  read_value;
	logic [7:0]  sound_latch_a;
	logic [7:0]  sound_latch_b;
	logic        last;

	// Predictor state.
	logic [7:0] shifter_msb;
	logic [7:0] shifter_lsb;
	logic [2:0] shifter_amount;
	logic [7:0] latch_a;
	logic [7:0] latch_b;
	logic [2:0] color_map [TABLE_DEPTH];

	bus_result_t expected_results [$];

	int n_errors = 0;
	int n_requests = 0;
	int n_video = 0;
	int n_received = 0;
	int cycle_count = 0;
	bit held_long = 1'b0;

	// Directed requests: field extremes, every action and the special cases.
	bus_req_t directed_rows [N_DIRECTED] = '{
		// Input ports and the shifter window right after reset.
		'{ACT_PORT_READ, PORT_IN_ZERO, 8'h00, 8'hA5, 8'h00, 8'h00, 1'b1, 8'hA5, 8'h00, 8'h00},
		'{ACT_PORT_READ, PORT_IN_ONE, 8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1, 8'hFF, 8'h00, 8'h00},
		'{ACT_PORT_READ, PORT_IN_TWO, 8'h00, 8'hFF, 8'hFF, 8'h5A, 1'b1, 8'h5A, 8'h00, 8'h00},
		'{ACT_PORT_READ, PORT_SHIFT_WINDOW, 8'h00, 8'hFF, 8'hFF, 8'hFF,
			1'b1, 8'h00, 8'h00, 8'h00},
		// Unknown ports read zero.
		'{ACT_PORT_READ, 16'd7, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00},
		'{ACT_PORT_READ, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00},
		// Sound latches, then the watchdog and an unknown port, which change nothing.
		'{ACT_PORT_WRITE, PORT_SOUND_A, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h00},
		'{ACT_PORT_WRITE, PORT_SOUND_B, 8'h81, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h81},
		'{ACT_PORT_WRITE, 16'd6, 8'h55, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h81},
		'{ACT_PORT_WRITE, 16'hFFFF, 8'hAA, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h81},
		// Shift pair loads, the full shift amount and the zero amount.
		'{ACT_PORT_WRITE, PORT_SHIFT_DATA, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_PORT_WRITE, PORT_SHIFT_DATA, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_PORT_WRITE, PORT_SHIFT_AMOUNT, 8'hFF, 8'h00, 8'h00, 8'h00,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_PORT_READ, PORT_SHIFT_WINDOW, 8'h00, 8'h00, 8'h00, 8'h00,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_PORT_WRITE, PORT_SHIFT_AMOUNT, 8'hF8, 8'h00, 8'h00, 8'h00,
			1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_PORT_READ, PORT_SHIFT_WINDOW, 8'h00, 8'h00, 8'h00, 8'h00,
			1'b0, 8'h00, 8'h00, 8'h00},
		// Video RAM at both ends of its window.
		'{ACT_MEM_WRITE, 16'h2400, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_MEM_WRITE, 16'h3FFF, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_MEM_WRITE, 16'h3FFF, 8'hAA, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
		// Memory writes just outside video RAM give one plain result.
		'{ACT_MEM_WRITE, 16'h23FF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h81},
		'{ACT_MEM_WRITE, 16'h4000, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h81},
		// Color table: last entry, an index out of range, and an entry then used.
		'{ACT_TABLE_WRITE, 16'h03FF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_TABLE_WRITE, 16'h0400, 8'h07, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'hFF, 8'h81},
		'{ACT_TABLE_WRITE, 16'h0080, 8'h02, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_MEM_WRITE, 16'h2400, 8'h01, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00},
		'{ACT_MEM_WRITE, 16'h3FFF, 8'hFF, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}
	};

	arcade_board_io_and_video_write_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.address(address),
		.data(data),
		.input_port_zero(input_port_zero),
		.input_port_one(input_port_one),
		.input_port_two(input_port_two),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_write(pixel_write),
		.pixel_row(pixel_row),
		.pixel_column(pixel_column),
		.pixel_color(pixel_color),
		.read_value(read_value),
		.sound_latch_a(sound_latch_a),
		.sound_latch_b(sound_latch_b),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Each mismatch prints one line, up to a cap, and is always counted.
	task automatic note_result_error(input string what);
		if (n_errors < MAX_PRINTED) begin
			$display("%0t: result %0d: %0s", $realtime, n_received, what);
		end
		n_errors++;
	endtask

	task automatic compare_result_field(input string name, input logic [7:0] got,
			input logic [7:0] want);
		if (got !== want) begin
			note_result_error($sformatf("%0s is %0h, expected %0h", name, got, want));
		end
	endtask

	// Updates the board state for one request and queues the results it causes.
	task automatic predict_bus_result(input bus_req_t r, input bit keep);
		logic [15:0] offset;
		logic [7:0]  column;
		logic [4:0]  byte_row;
		logic [2:0]  hue;
		logic [15:0] window;
		logic [7:0]  rv;
		int          idx;
		bus_result_t res;
		rv = 8'd0;
		if (r.act == ACT_MEM_WRITE && r.addr >= VIDEO_FIRST && r.addr < VIDEO_END) begin
			// A video byte becomes eight pixels stacked upward, bit 0 lowest on screen.
			offset = r.addr - VIDEO_FIRST;
			column = offset[12:5];
			byte_row = offset[4:0];
			idx = (int'(COLOR_BASE) + int'(byte_row) + 32 * (int'(column) / 8)) % TABLE_DEPTH;
			hue = color_map[idx];
			for (int i = 0; i < 8; i++) begin
				res = '{1'b1, 8'(255 - 8 * int'(byte_row) - i), column,
					r.dat[i] ? hue : COLOR_NONE, 8'd0, latch_a, latch_b, i == 7};
				if (keep) expected_results.push_back(res);
			end
			n_video++;
		end else begin
			case (r.act)
				ACT_PORT_READ: begin
					case (r.addr)
						PORT_IN_ZERO: rv = r.p0;
						PORT_IN_ONE: rv = r.p1;
						PORT_IN_TWO: rv = r.p2;
						PORT_SHIFT_WINDOW: begin
							window = {shifter_msb, shifter_lsb} << shifter_amount;
							rv = window[15:8];
						end
						default: rv = 8'd0;
					endcase
				end
				ACT_PORT_WRITE: begin
					case (r.addr)
						PORT_SHIFT_AMOUNT: shifter_amount = r.dat[2:0];
						PORT_SOUND_A: latch_a = r.dat;
						PORT_SHIFT_DATA: begin
							shifter_lsb = shifter_msb;
							shifter_msb = r.dat;
						end
						PORT_SOUND_B: latch_b = r.dat;
						default: ;
					endcase
				end
				ACT_TABLE_WRITE: begin
					if (int'(r.addr) < TABLE_DEPTH) color_map[r.addr] = r.dat[2:0];
				end
				default: ;
			endcase
			res = '{1'b0, 8'd0, 8'd0, COLOR_NONE, rv, latch_a, latch_b, 1'b1};
			if (keep) expected_results.push_back(res);
		end
	endtask

	// Random request, mostly well-formed video, port and table traffic.
	function automatic bus_req_t draw_request();
		bus_req_t r;
		int pick;
		r = '0;
		pick = $urandom_range(0, 99);
		r.dat = 8'($urandom);
		r.p0 = 8'($urandom);
		r.p1 = 8'($urandom);
		r.p2 = 8'($urandom);
		if (pick < 35) begin
			r.act = ACT_MEM_WRITE;
			r.addr = VIDEO_FIRST + 16'($urandom_range(0, 16'h1BFF));
		end else if (pick < 40) begin
			r.act = ACT_MEM_WRITE;
			r.addr = 16'($urandom);
		end else if (pick < 60) begin
			r.act = ACT_PORT_READ;
			r.addr = (pick < 57) ? 16'($urandom_range(0, 3)) : 16'($urandom);
		end else if (pick < 82) begin
			r.act = ACT_PORT_WRITE;
			r.addr = (pick < 78) ? 16'($urandom_range(2, 6)) : 16'($urandom);
		end else begin
			r.act = ACT_TABLE_WRITE;
			r.addr = (pick < 97) ? 16'($urandom_range(int'(COLOR_BASE), TABLE_DEPTH - 1))
				: 16'($urandom);
		end
		return r;
	endfunction

	// Offers one request after a gap and returns at the edge that accepts it.
	task automatic issue_request(input bus_req_t r, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= r.act;
		address <= r.addr;
		data <= r.dat;
		input_port_zero <= r.p0;
		input_port_one <= r.p1;
		input_port_two <= r.p2;
		@(negedge clk);
		while (!in_ready) begin
			@(posedge clk);
			@(negedge clk);
		end
		@(posedge clk);
		n_requests++;
	endtask

	// Stimulus: power-up overlay, reset, directed table, then random traffic.
	initial begin : request_source
		bus_req_t req;
		int gap;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (k >= 1024) color_map[k] = COLOR_NONE;
			else if (k % 32 >= 2 && k % 32 <= 8) color_map[k] = COLOR_RED;
			else if (k % 32 >= 24 && k % 32 <= 27) color_map[k] = COLOR_GREEN;
			else color_map[k] = COLOR_WHITE;
		end
		shifter_msb = 8'd0;
		shifter_lsb = 8'd0;
		shifter_amount = 3'd0;
		latch_a = 8'd0;
		latch_b = 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[n]) begin
			req = directed_rows[n];
			issue_request(req, $urandom_range(0, 19));
			predict_bus_result(req, !req.typed);
			if (req.typed) begin
				expected_results.push_back('{1'b0, 8'd0, 8'd0, COLOR_NONE, req.t_rv,
					req.t_sa, req.t_sb, 1'b1});
			end
		end

		for (int i = 0; i < N_RANDOM; i++) begin
			// Once, let the block drain completely before offering more.
			if (i == PAUSE_AT) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (expected_results.size() != 0) @(posedge clk);
			end
			req = draw_request();
			gap = ((i / 40) % 4 == 3) ? 0 : $urandom_range(0, 19);
			issue_request(req, gap);
			predict_bus_result(req, 1'b1);
		end
		in_valid <= 1'b0;

		// Drain and give a stray extra result time to show up.
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d bus requests, %0d of them video byte writes; %0d results checked.",
			n_requests, n_video, n_received);
		$display("Mismatches found: %0d.", n_errors);
		if (n_errors == 0) begin
			$display("PASS arcade_board_io_and_video_write_top");
		end else begin
			$display("FAIL arcade_board_io_and_video_write_top");
		end
		$finish;
	end

	// Result sink: random stalls, one long hold, and a field-by-field check.
	initial begin : result_sink
		bus_result_t seen;
		bus_result_t want;
		int stall;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (n_received == LONG_HOLD_AT && !held_long) begin
				held_long = 1'b1;
				stall = LONG_HOLD;
			end else if ((n_received / 60) % 4 == 3) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 19);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid) begin
				@(posedge clk);
				@(negedge clk);
			end
			seen = '{pixel_write, pixel_row, pixel_column, pixel_color, read_value,
				sound_latch_a, sound_latch_b, last};
			@(posedge clk);
			n_received++;
			if (expected_results.size() == 0) begin
				note_result_error("result arrived with no request outstanding");
			end else begin
				want = expected_results.pop_front();
				compare_result_field("pixel_write", seen.pw, want.pw);
				compare_result_field("pixel_row", seen.row, want.row);
				compare_result_field("pixel_column", seen.col, want.col);
				compare_result_field("pixel_color", seen.color, want.color);
				compare_result_field("read_value", seen.rv, want.rv);
				compare_result_field("sound_latch_a", seen.sa, want.sa);
				compare_result_field("sound_latch_b", seen.sb, want.sb);
				compare_result_field("last", seen.lst, want.lst);
			end
		end
	end

	// Timeout guard.
	initial begin : cycle_guard
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles with %0d results outstanding.",
			cycle_count, expected_results.size());
		$display("FAIL arcade_board_io_and_video_write_top");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/abvw_pkg.sv
hw/rtl/abvw_color_mem.sv
hw/rtl/abvw_exec.sv
hw/rtl/abvw_out.sv
hw/rtl/arcade_board_io_and_video_write_top.sv
dv/arcade_board_io_and_video_write_top_tb.sv
